>>> design/hfd_pkg.sv
// Shared payload types of the HTTP request framing detector.
package hfd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_request;
    } in_t;

    typedef struct packed {
        logic        header_done;
        logic        request_complete;
        logic [30:0] body_length;
        logic [31:0] header_length;
    } out_t;

endpackage

>>> design/hfd_in_reg.sv
// Input pipeline register that holds one accepted byte until the tracker takes it.
module hfd_in_reg (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  hfd_pkg::in_t s_item,
    output logic         hold_valid,
    output hfd_pkg::in_t hold_item,
    input  logic         take
);

    logic         valid_reg;
    logic         valid_next;
    hfd_pkg::in_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> design/hfd_tracker.sv
// Per-byte framing state: blank-line search, Content-Length match and value parse.
module hfd_tracker #(
    parameter int COUNT_WIDTH  = 32,
    parameter int LENGTH_WIDTH = 31
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  hfd_pkg::in_t  item,
    output hfd_pkg::out_t result
);

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [3:0] PREFIX_LEN = 4'd15;
    localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = '1;
    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;
    localparam int HW   = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam int BW   = (LENGTH_WIDTH > 31) ? LENGTH_WIDTH : 31;
    localparam int CMPW = (COUNT_WIDTH > LENGTH_WIDTH) ? COUNT_WIDTH : LENGTH_WIDTH;
    localparam int PW   = LENGTH_WIDTH + 4;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_BLANK = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_END   = 4'b1000
    } phase_t;

    // Lower-case "content-length:"
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h6C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            4'd14:   ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    logic [23:0]             recent_reg, recent_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                    ended_reg, ended_next;
    logic [COUNT_WIDTH-1:0]  hsize_reg, hsize_next;
    logic                    reqline_reg, reqline_next;
    logic                    line_start_reg, line_start_next;
    logic [3:0]              match_reg, match_next;
    logic                    mismatch_reg, mismatch_next;
    logic                    found_reg, found_next;
    phase_t                  phase_reg, phase_next;
    logic                    negative_reg, negative_next;
    logic [LENGTH_WIDTH-1:0] value_reg, value_next;
    logic                    done_reg, done_next;

    logic [LENGTH_WIDTH-1:0] body_next;
    logic [HW-1:0]           hsize_wide;
    logic [BW-1:0]           body_wide;

    always_comb begin
        logic [7:0]              c;
        logic [7:0]              c_low;
        logic                    is_digit;
        logic                    is_blank;
        logic                    do_acc;
        logic [PW-1:0]           product;
        logic [COUNT_WIDTH-1:0]  span;
        logic [23:0]             cur_recent;
        logic [COUNT_WIDTH-1:0]  cur_count;
        logic                    cur_ended;
        logic                    cur_done;

        c        = item.data_byte;
        c_low    = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
        is_digit = (c >= 8'h30 && c <= 8'h39);
        is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
        do_acc   = 1'b0;

        // Start from the cleared state when this byte opens a new request
        if (item.new_request) begin
            cur_recent      = '0;
            cur_count       = '0;
            cur_ended       = 1'b0;
            cur_done        = 1'b0;
            hsize_next      = '0;
            reqline_next    = 1'b0;
            line_start_next = 1'b1;
            match_next      = '0;
            mismatch_next   = 1'b0;
            found_next      = 1'b0;
            phase_next      = PH_IDLE;
            negative_next   = 1'b0;
            value_next      = '0;
        end else begin
            cur_recent      = recent_reg;
            cur_count       = count_reg;
            cur_ended       = ended_reg;
            cur_done        = done_reg;
            hsize_next      = hsize_reg;
            reqline_next    = reqline_reg;
            line_start_next = line_start_reg;
            match_next      = match_reg;
            mismatch_next   = mismatch_reg;
            found_next      = found_reg;
            phase_next      = phase_reg;
            negative_next   = negative_reg;
            value_next      = value_reg;
        end

        count_next = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
        ended_next = cur_ended;

        if (!cur_ended) begin
            if (c == CHAR_CR || c == CHAR_LF) begin
                line_start_next = 1'b1;
                if (phase_next == PH_BLANK || phase_next == PH_DIGIT) begin
                    phase_next = PH_END;
                end
            end else if (found_next) begin
                case (phase_next)
                    PH_BLANK: begin
                        if (is_blank) begin
                            phase_next = PH_BLANK;
                        end else if (c == 8'h2B || c == 8'h2D) begin
                            negative_next = (c == 8'h2D);
                            phase_next    = PH_DIGIT;
                        end else if (!is_digit) begin
                            phase_next = PH_END;
                        end else begin
                            phase_next = PH_DIGIT;
                            do_acc     = 1'b1;
                        end
                    end
                    PH_DIGIT: begin
                        if (!is_digit) begin
                            phase_next = PH_END;
                        end else begin
                            do_acc = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = phase_next;
                    end
                endcase
            end else begin
                if (line_start_next) begin
                    line_start_next = 1'b0;
                    if (!reqline_next) begin
                        // The request line never matches
                        reqline_next  = 1'b1;
                        mismatch_next = 1'b1;
                    end else begin
                        match_next    = '0;
                        mismatch_next = 1'b0;
                    end
                end
                if (!mismatch_next && match_next < PREFIX_LEN) begin
                    if (c_low == prefix_char(match_next)) begin
                        match_next = match_next + 4'd1;
                        if (match_next == PREFIX_LEN) begin
                            found_next    = 1'b1;
                            phase_next    = PH_BLANK;
                            mismatch_next = 1'b1;
                        end
                    end else begin
                        mismatch_next = 1'b1;
                    end
                end
            end

            if (c == CHAR_LF && (cur_recent[7:0] == CHAR_LF ||
                    (cur_recent[7:0] == CHAR_CR && cur_recent[15:8] == CHAR_LF &&
                     cur_recent[23:16] == CHAR_CR))) begin
                ended_next = 1'b1;
                hsize_next = count_next;
            end
        end

        // value * 10 + digit, saturating
        product = ({2'b00, value_next, 2'b00} << 1) + {3'b000, value_next, 1'b0}
                + PW'(c - 8'h30);
        if (do_acc) begin
            if (product > PW'(LENGTH_MAX)) begin
                value_next = LENGTH_MAX;
            end else begin
                value_next = product[LENGTH_WIDTH-1:0];
            end
        end

        recent_next = {cur_recent[15:0], c};
        body_next   = negative_next ? '0 : value_next;
        span        = count_next - hsize_next;
        done_next   = cur_done;
        if (ended_next && !cur_done && (CMPW'(span) >= CMPW'(body_next))) begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg     <= '0;
            count_reg      <= '0;
            ended_reg      <= 1'b0;
            hsize_reg      <= '0;
            reqline_reg    <= 1'b0;
            line_start_reg <= 1'b1;
            match_reg      <= '0;
            mismatch_reg   <= 1'b0;
            found_reg      <= 1'b0;
            phase_reg      <= PH_IDLE;
            negative_reg   <= 1'b0;
            value_reg      <= '0;
            done_reg       <= 1'b0;
        end else if (en) begin
            recent_reg     <= recent_next;
            count_reg      <= count_next;
            ended_reg      <= ended_next;
            hsize_reg      <= hsize_next;
            reqline_reg    <= reqline_next;
            line_start_reg <= line_start_next;
            match_reg      <= match_next;
            mismatch_reg   <= mismatch_next;
            found_reg      <= found_next;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            value_reg      <= value_next;
            done_reg       <= done_next;
        end
    end

    assign hsize_wide = HW'(hsize_next);
    assign body_wide  = BW'(body_next);

    assign result.header_done      = ended_next;
    assign result.request_complete = done_next;
    assign result.body_length      = body_wide[30:0];
    assign result.header_length    = hsize_wide[31:0];

endmodule

>>> design/http_request_framing_detector_unit.sv
// Top level of the HTTP request framing detector: input stage, tracker, result register.
//
// Usage:
//   s_valid/s_ready/s_item carry one request byte per transaction, with
//   new_request set on the first byte of each request to clear all framing state.
//   m_valid/m_ready/m_result return exactly one result per byte: header_done,
//   request_complete, the parsed Content-Length value and the header length.
//   A result is registered: each byte passes through the input register and then
//   the per-byte update into the result register. Throughput is one byte per
//   cycle while the receiver does not stall; the per-byte update is a single
//   pass of compare logic plus one multiply-by-ten add and one count subtract/compare.
//   When the receiver stalls, the result register holds its transaction, the
//   input register fills, and s_ready drops only once both are occupied.
//   Reset (aresetn low, synchronous) empties both stages and returns the framing
//   state to the start of a request.
//
module http_request_framing_detector_unit #(
    parameter int COUNT_WIDTH  = 32,
    parameter int LENGTH_WIDTH = 31
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hfd_pkg::in_t  s_item,
    output logic          m_valid,
    input  logic          m_ready,
    output hfd_pkg::out_t m_result
);

    logic          hold_valid;
    hfd_pkg::in_t  hold_item;
    logic          advance;
    hfd_pkg::out_t step_result;

    logic          out_valid_reg;
    logic          out_valid_next;
    hfd_pkg::out_t out_data_reg;

    // Move the held byte forward whenever the result register can take it
    assign advance = hold_valid && (!out_valid_reg || m_ready);

    hfd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .hold_valid (hold_valid),
        .hold_item  (hold_item),
        .take       (advance)
    );

    hfd_tracker #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (hold_item),
        .result  (step_result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_data_reg;

    a_complete_needs_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_result.request_complete || m_result.header_done))
        else $error("request_complete without header_done");

    a_length_only_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_result.header_done) |-> (m_result.header_length == 32'd0))
        else $error("header_length nonzero before header end");

    a_ready_when_output_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register empty");

    a_result_from_held_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> $past(hold_valid))
        else $error("result appeared without a held byte");

endmodule

>>> dv/http_request_framing_detector_unit_test.sv
// Testbench for the HTTP request framing detector: random request streams checked per byte.
module http_request_framing_detector_unit_test;

    typedef enum logic [3:0] {
        NUM_IDLE   = 4'b0001,
        NUM_BLANKS = 4'b0010,
        NUM_DIGITS = 4'b0100,
        NUM_ENDED  = 4'b1000
    } num_phase_t;

    typedef struct packed {
        hfd_pkg::in_t item;
        logic         drain;
    } stim_t;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";

    localparam int PREFIX_LEN = 15;
    localparam logic [8*PREFIX_LEN-1:0] CL_PREFIX = "content-length:";
    localparam longint unsigned LEN_MAX = 64'h7FFF_FFFF;
    localparam int STIM_BYTES = 860;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    hfd_pkg::in_t  s_item  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    hfd_pkg::out_t m_result;

    http_request_framing_detector_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // Framing tracker state
    logic [23:0] hist;
    logic [31:0] seen_count;
    logic        hdr_end;
    logic [31:0] hdr_size;
    logic        reqline_done;
    logic        line_start;
    int          prefix_pos;
    logic        line_bad;
    logic        cl_found;
    num_phase_t  num_phase;
    logic        neg;
    logic [30:0] cl_value;
    logic        complete;

    stim_t         pending_bytes[$];
    hfd_pkg::out_t expected_frames[$];
    logic [7:0]    req_buf[$];

    int            mismatch_count     = 0;
    int            results_checked    = 0;
    int            requests_built     = 0;
    int            headers_framed     = 0;
    int            requests_completed = 0;
    int            tx_gap             = 0;
    int            rx_stall           = 0;
    int            rx_wait;
    bit            tx_calm            = 1'b0;
    bit            rx_calm            = 1'b0;
    stim_t         stim;
    hfd_pkg::out_t predicted;
    hfd_pkg::out_t want;

    task automatic clear_frame();
        hist         = '0;
        seen_count   = '0;
        hdr_end      = 1'b0;
        hdr_size     = '0;
        reqline_done = 1'b0;
        line_start   = 1'b1;
        prefix_pos   = 0;
        line_bad     = 1'b0;
        cl_found     = 1'b0;
        num_phase    = NUM_IDLE;
        neg          = 1'b0;
        cl_value     = '0;
        complete     = 1'b0;
    endtask

    task automatic advance_frame(input hfd_pkg::in_t it, output hfd_pkg::out_t res);
        logic [7:0]      c;
        logic [7:0]      lc;
        logic            is_digit;
        logic            is_blank;
        logic            take;
        logic [30:0]     body;
        longint unsigned d;
        longint unsigned acc;
        c = it.data_byte;
        if (it.new_request) clear_frame();
        if (seen_count != '1) seen_count++;
        if (!hdr_end) begin
            is_digit = (c >= "0" && c <= "9");
            is_blank = (c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF);
            take = 1'b0;
            if (c == CH_CR || c == CH_LF) begin
                line_start = 1'b1;
                if (num_phase == NUM_BLANKS || num_phase == NUM_DIGITS) num_phase = NUM_ENDED;
            end else if (cl_found) begin
                if (num_phase == NUM_BLANKS) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        neg = (c == CH_MINUS);
                        num_phase = NUM_DIGITS;
                    end else if (is_digit) begin
                        num_phase = NUM_DIGITS;
                        take = 1'b1;
                    end else if (!is_blank) begin
                        num_phase = NUM_ENDED;
                    end
                end else if (num_phase == NUM_DIGITS) begin
                    if (is_digit) take = 1'b1;
                    else num_phase = NUM_ENDED;
                end
                if (take) begin
                    d = c[3:0];
                    acc = cl_value;
                    // saturate instead of wrapping
                    if (acc > (LEN_MAX - d) / 10) acc = LEN_MAX;
                    else acc = acc * 10 + d;
                    cl_value = acc[30:0];
                end
            end else begin
                // the first non-empty line is the request line and never matches
                if (line_start) begin
                    line_start = 1'b0;
                    if (!reqline_done) begin
                        reqline_done = 1'b1;
                        line_bad = 1'b1;
                    end else begin
                        prefix_pos = 0;
                        line_bad = 1'b0;
                    end
                end
                if (!line_bad && prefix_pos < PREFIX_LEN) begin
                    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                    if (lc == CL_PREFIX[8*(PREFIX_LEN-1-prefix_pos) +: 8]) begin
                        prefix_pos++;
                        if (prefix_pos == PREFIX_LEN) begin
                            cl_found = 1'b1;
                            num_phase = NUM_BLANKS;
                            line_bad = 1'b1;
                        end
                    end else begin
                        line_bad = 1'b1;
                    end
                end
            end
            if (c == CH_LF && (hist[7:0] == CH_LF ||
                    (hist[7:0] == CH_CR && hist[15:8] == CH_LF && hist[23:16] == CH_CR))) begin
                hdr_end = 1'b1;
                hdr_size = seen_count;
                headers_framed++;
            end
        end
        hist = {hist[15:0], c};
        body = neg ? '0 : cl_value;
        if (hdr_end && !complete && (seen_count - hdr_size) >= {1'b0, body}) begin
            complete = 1'b1;
            requests_completed++;
        end
        res.header_done      = hdr_end;
        res.request_complete = complete;
        res.body_length      = body;
        res.header_length    = hdr_size;
    endtask

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) req_buf.push_back(s[i]);
    endtask

    task automatic add_eol(input bit crlf);
        bit use_cr;
        use_cr = crlf ^ ($urandom_range(0, 15) == 0);
        if (use_cr) req_buf.push_back(CH_CR);
        req_buf.push_back(CH_LF);
    endtask

    task automatic push_byte(input logic [7:0] c, input bit is_start, input bit drain);
        stim_t st;
        st.item.data_byte   = c;
        st.item.new_request = is_start;
        st.drain            = drain;
        pending_bytes.push_back(st);
    endtask

    // Move the assembled request into the stimulus, cut to keep bytes.
    task automatic flush_request(input int keep, input bit drain);
        for (int i = 0; i < keep && i < req_buf.size(); i++)
            push_byte(req_buf[i], i == 0, drain && i == 0);
        req_buf.delete();
        requests_built++;
    endtask

    task automatic add_length_line(output int declared);
        logic [7:0] c;
        int         sign_pick;
        int         mode;
        int         v;
        int         n;
        for (int k = 0; k < PREFIX_LEN; k++) begin
            c = CL_PREFIX[8*(PREFIX_LEN-1-k) +: 8];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
            req_buf.push_back(c);
        end
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0: req_buf.push_back(CH_SP);
                1: req_buf.push_back(CH_TAB);
                2: req_buf.push_back(CH_VT);
                default: req_buf.push_back(CH_FF);
            endcase
        end
        sign_pick = $urandom_range(0, 7);
        if (sign_pick == 0) req_buf.push_back(CH_PLUS);
        if (sign_pick == 1) req_buf.push_back(CH_MINUS);
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            declared = 0;
        end else if (mode == 1) begin
            // ten to thirteen digits, mostly past the 31-bit length limit: usually clamps
            n = $urandom_range(10, 13);
            req_buf.push_back("0" + 8'($urandom_range(1, 9)));
            for (int k = 1; k < n; k++) req_buf.push_back("0" + 8'($urandom_range(0, 9)));
            declared = 1000;
        end else begin
            v = $urandom_range(0, 24);
            add_text($sformatf("%0d", v));
            declared = v;
        end
        if ($urandom_range(0, 4) == 0) add_text("z 9");
        if (sign_pick == 1) declared = 0;
    endtask

    task automatic push_request(input bit broken, input bit drain);
        bit crlf;
        bit has_cl;
        int n_hdr;
        int cl_slot;
        int declared;
        int dummy;
        int body_n;
        int k;
        logic [7:0] c;
        crlf = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) add_eol(crlf);
        case ($urandom_range(0, 9))
            0: add_text("Content-Length: 3");
            1, 2, 3: add_text("POST /a HTTP/1.1");
            default: add_text("GET /");
        endcase
        add_eol(crlf);
        n_hdr    = $urandom_range(0, 3);
        has_cl   = ($urandom_range(0, 3) != 0);
        cl_slot  = $urandom_range(0, n_hdr);
        declared = 0;
        for (int i = 0; i <= n_hdr; i++) begin
            if (has_cl && i == cl_slot) begin
                add_length_line(declared);
                add_eol(crlf);
                // a second length line must be ignored
                if ($urandom_range(0, 3) == 0) begin
                    add_length_line(dummy);
                    add_eol(crlf);
                end
            end
            if (i < n_hdr) begin
                case ($urandom_range(0, 2))
                    0: add_text("Host: h");
                    1: begin
                        k = $urandom_range(1, PREFIX_LEN - 1);
                        for (int j = 0; j < k; j++)
                            req_buf.push_back(CL_PREFIX[8*(PREFIX_LEN-1-j) +: 8]);
                        add_text("x: 1");
                    end
                    default: begin
                        k = $urandom_range(1, 6);
                        for (int j = 0; j < k; j++) begin
                            c = 8'($urandom_range(0, 255));
                            req_buf.push_back(c == CH_LF ? 8'h00 : c);
                        end
                    end
                endcase
                add_eol(crlf);
            end
        end
        add_eol(crlf);
        if (declared >= 100) body_n = $urandom_range(0, 4);
        else if ($urandom_range(0, 3) == 0) body_n = $urandom_range(0, declared);
        else body_n = declared + $urandom_range(0, 2);
        for (int i = 0; i < body_n; i++) req_buf.push_back(8'($urandom_range(0, 255)));
        flush_request(broken ? $urandom_range(1, req_buf.size()) : req_buf.size(), drain);
    endtask

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Sender: one transaction per pending byte, with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                advance_frame(s_item, predicted);
                expected_frames.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    s_valid <= 1'b0;
                    tx_gap  <= tx_gap - 1;
                end else if (pending_bytes.size() != 0 &&
                             !(pending_bytes[0].drain && expected_frames.size() != 0)) begin
                    stim = pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_item  <= stim.item;
                    if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
                    tx_gap <= draw_gap(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each result transaction against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: done=%0b complete=%0b body=%0d hdr=%0d",
                                 m_result.header_done, m_result.request_complete,
                                 m_result.body_length, m_result.header_length);
                end else begin
                    want = expected_frames.pop_front();
                    results_checked++;
                    if (m_result.header_done !== want.header_done ||
                        m_result.request_complete !== want.request_complete ||
                        m_result.body_length !== want.body_length ||
                        m_result.header_length !== want.header_length) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d mismatch: exp done=%0b complete=%0b body=%0d",
                                      " hdr=%0d, got done=%0b complete=%0b body=%0d hdr=%0d"},
                                     results_checked, want.header_done,
                                     want.request_complete, want.body_length,
                                     want.header_length, m_result.header_done,
                                     m_result.request_complete, m_result.body_length,
                                     m_result.header_length);
                    end
                end
                if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
                rx_wait = draw_gap(rx_calm);
                m_ready  <= (rx_wait == 0);
                rx_stall <= (rx_wait == 0) ? 0 : rx_wait - 1;
            end else if (rx_stall != 0) begin
                m_ready  <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(8 * 200000);
        $display("[http_request_framing_detector_unit] ERROR");
        $finish;
    end

    initial begin
        int pick;
        bit forced_drain;
        clear_frame();

        // Leading empty line, zero and all-ones bytes in the request line,
        // mixed case, blanks and an oversized length value.
        req_buf.push_back(CH_LF);
        add_text("G");
        req_buf.push_back(8'h00);
        req_buf.push_back(8'hFF);
        req_buf.push_back(CH_LF);
        add_text("content-LENGTH:");
        req_buf.push_back(CH_SP);
        req_buf.push_back(CH_TAB);
        add_text("9999999999");
        req_buf.push_back(CH_LF);
        req_buf.push_back(CH_LF);
        req_buf.push_back(8'hFF);
        flush_request(req_buf.size(), 1'b0);

        forced_drain = 1'b1;
        while (pending_bytes.size() < STIM_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // raw noise, sometimes restarting the request mid-stream
                repeat ($urandom_range(5, 30))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0);
            end else begin
                push_request(pick == 1, forced_drain || $urandom_range(0, 11) == 0);
                forced_drain = 1'b0;
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid || expected_frames.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("checked %0d per-byte results over %0d request streams", results_checked,
                 requests_built);
        $display("%0d header blocks ended, %0d requests reached completion", headers_framed,
                 requests_completed);
        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("[http_request_framing_detector_unit] OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("[http_request_framing_detector_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> http_request_framing_detector_unit.f
design/hfd_pkg.sv
design/hfd_in_reg.sv
design/hfd_tracker.sv
design/http_request_framing_detector_unit.sv
dv/http_request_framing_detector_unit_test.sv
